@@ rtl/core/tty_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tty_pkg
// shared types, character codes and register indexes of the terminal output
// post-processor
// ----------------------------------------------------------------------------
package tty_pkg;

    localparam int TAB_WIDTH_DEF   = 8;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUT_COL_BITS    = 16;
    localparam int ADDR_BITS       = 5;
    localparam int DATA_BITS       = 32;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CTL_HI = 8'h1F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        ST_EMIT = 2'd0,
        ST_SUPP = 2'd1,
        ST_ROOM = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_POST_ENABLE   = 3'd0,
        REG_NL_TO_CRNL    = 3'd1,
        REG_CR_TO_NL      = 3'd2,
        REG_NO_CR_AT_COL0 = 3'd3,
        REG_NL_RETURNS    = 3'd4,
        REG_UPPER_CASE    = 3'd5,
        REG_EXPAND_TABS   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic post_enable;
        logic nl_to_crnl;
        logic cr_to_nl;
        logic no_cr_at_col0;
        logic nl_returns;
        logic upper_case;
        logic expand_tabs;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        post_enable:   1'b1,
        nl_to_crnl:    1'b1,
        cr_to_nl:      1'b0,
        no_cr_at_col0: 1'b0,
        nl_returns:    1'b0,
        upper_case:    1'b0,
        expand_tabs:   1'b0
    };

    // what the back end has to send for one input byte
    typedef struct packed {
        logic [7:0] ch;
        logic       bvalid;
        status_t    st;
        logic       crlf;
    } desc_t;

endpackage
`default_nettype wire

@@ rtl/core/tty_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tty_front
// takes input bytes, classifies them under the output modes and keeps the
// column, canonical column and tab phase
// ----------------------------------------------------------------------------
module tty_front #(
    parameter int TAB_WIDTH   = tty_pkg::TAB_WIDTH_DEF,
    parameter int COLUMN_BITS = tty_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tty_pkg::cfg_t                    cfg,
    input  wire logic [7:0]                       in_byte,
    input  wire logic [7:0]                       room,
    input  wire logic                             take,
    output tty_pkg::desc_t                        desc,
    output logic [$clog2(TAB_WIDTH+1)-1:0]        beats,
    output logic [COLUMN_BITS-1:0]                col_after,
    output logic [COLUMN_BITS-1:0]                canon_after
);
    import tty_pkg::*;

    localparam int CW = COLUMN_BITS;
    localparam int PW = $clog2(TAB_WIDTH);
    localparam int NW = $clog2(TAB_WIDTH + 1);
    localparam logic [CW-1:0] COL_MAX = '1;
    localparam longint unsigned COL_MAX_L = (64'd1 << CW) - 64'd1;
    localparam logic [PW-1:0] MAX_PH = PW'(COL_MAX_L % TAB_WIDTH);
    localparam logic [PW-1:0] PH_LAST = PW'(TAB_WIDTH - 1);
    localparam logic [NW-1:0] TABN = NW'(TAB_WIDTH);

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] canon_reg, canon_next;
    logic [PW-1:0] phase_reg, phase_next;

    logic [NW-1:0] tab_n;
    logic [CW:0]   tab_sum;
    logic [CW-1:0] tab_col;
    logic [PW-1:0] tab_phase;
    logic [CW-1:0] inc_col;
    logic [PW-1:0] inc_phase;
    logic [CW-1:0] dec_col;
    logic [PW-1:0] dec_phase;
    logic          room_zero;
    logic          printable;
    logic          lower;

    assign tab_n     = TABN - NW'(phase_reg);
    assign tab_sum   = {1'b0, col_reg} + (CW+1)'(tab_n);
    assign tab_col   = tab_sum[CW] ? COL_MAX : tab_sum[CW-1:0];
    assign tab_phase = tab_sum[CW] ? MAX_PH : '0;
    assign inc_col   = (col_reg == COL_MAX) ? col_reg : col_reg + CW'(1);
    assign inc_phase = (col_reg == COL_MAX) ? phase_reg :
                       ((phase_reg == PH_LAST) ? '0 : phase_reg + PW'(1));
    assign dec_col   = (col_reg == '0) ? col_reg : col_reg - CW'(1);
    assign dec_phase = (col_reg == '0) ? phase_reg :
                       ((phase_reg == '0) ? PH_LAST : phase_reg - PW'(1));
    assign room_zero = (room == 8'd0);
    assign printable = !(in_byte inside {[8'h00:CH_CTL_HI], CH_DEL});
    assign lower     = in_byte inside {[CH_LOW_A:CH_LOW_Z]};

    always_comb
    begin
        desc.ch     = in_byte;
        desc.bvalid = 1'b1;
        desc.st     = ST_EMIT;
        desc.crlf   = 1'b0;
        beats       = NW'(1);
        col_next    = col_reg;
        canon_next  = canon_reg;
        phase_next  = phase_reg;

        if (room_zero)
        begin
            desc.ch     = 8'd0;
            desc.bvalid = 1'b0;
            desc.st     = ST_ROOM;
        end
        else if (cfg.post_enable)
        begin
            case (in_byte)
                CH_LF:
                begin
                    if (cfg.nl_returns)
                    begin
                        col_next   = '0;
                        phase_next = '0;
                    end
                    if (cfg.nl_to_crnl)
                    begin
                        if (room < 8'd2)
                        begin
                            desc.ch     = 8'd0;
                            desc.bvalid = 1'b0;
                            desc.st     = ST_ROOM;
                        end
                        else
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            canon_next = '0;
                            desc.crlf  = 1'b1;
                            beats      = NW'(2);
                        end
                    end
                    else
                    begin
                        canon_next = cfg.nl_returns ? '0 : col_reg;
                    end
                end
                CH_CR:
                begin
                    if (cfg.no_cr_at_col0 && col_reg == '0)
                    begin
                        desc.ch     = 8'd0;
                        desc.bvalid = 1'b0;
                        desc.st     = ST_SUPP;
                    end
                    else if (cfg.cr_to_nl)
                    begin
                        desc.ch = CH_LF;
                        if (cfg.nl_returns)
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            canon_next = '0;
                        end
                    end
                    else
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        canon_next = '0;
                    end
                end
                CH_TAB:
                begin
                    if (cfg.expand_tabs && room < 8'(tab_n))
                    begin
                        desc.ch     = 8'd0;
                        desc.bvalid = 1'b0;
                        desc.st     = ST_ROOM;
                    end
                    else
                    begin
                        col_next   = tab_col;
                        phase_next = tab_phase;
                        if (cfg.expand_tabs)
                        begin
                            desc.ch = CH_SPACE;
                            beats   = tab_n;
                        end
                    end
                end
                CH_BS:
                begin
                    col_next   = dec_col;
                    phase_next = dec_phase;
                end
                default:
                begin
                    if (printable)
                    begin
                        if (cfg.upper_case && lower)
                        begin
                            desc.ch = in_byte - CASE_OFFSET;
                        end
                        col_next   = inc_col;
                        phase_next = inc_phase;
                    end
                end
            endcase
        end
    end

    assign col_after   = col_next;
    assign canon_after = canon_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            canon_reg <= '0;
            phase_reg <= '0;
        end
        else if (take)
        begin
            col_reg   <= col_next;
            canon_reg <= canon_next;
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tty_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tty_fifo
// short first-in first-out queue between the front and back ends
// ----------------------------------------------------------------------------
module tty_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tty_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output logic                  empty
);
    import tty_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tty_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tty_back
// expands queued entries into result beats: cr-lf pairs and tab runs,
// one beat per cycle while res_ready is high, through a registered output stage
// ----------------------------------------------------------------------------
module tty_back #(
    parameter int TAB_WIDTH   = tty_pkg::TAB_WIDTH_DEF,
    parameter int COLUMN_BITS = tty_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_empty,
    input  wire tty_pkg::desc_t                       q_desc,
    input  wire logic [$clog2(TAB_WIDTH+1)-1:0]       q_beats,
    input  wire logic [COLUMN_BITS-1:0]               q_col,
    input  wire logic [COLUMN_BITS-1:0]               q_canon,
    output logic                                      pop,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output logic [7:0]                                out_byte,
    output logic                                      out_valid,
    output logic                                      last,
    output logic [1:0]                                status,
    output logic [tty_pkg::OUT_COL_BITS-1:0]          column_now,
    output logic [tty_pkg::OUT_COL_BITS-1:0]          canon_column_now
);
    import tty_pkg::*;

    localparam int NW = $clog2(TAB_WIDTH + 1);
    localparam int CW = COLUMN_BITS;
    localparam int XW = CW + OUT_COL_BITS;

    logic [NW-1:0]  idx_reg, idx_next;
    logic           res_valid_reg, res_valid_next;
    logic [7:0]     byte_reg;
    logic           bvalid_reg;
    logic           last_reg;
    status_t        status_reg;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  canon_reg;

    logic           load;
    logic           fire;
    logic           beat_last;
    logic [7:0]     beat_byte;
    logic [XW-1:0]  col_ext;
    logic [XW-1:0]  canon_ext;

    assign load      = !res_valid_reg || res_ready;
    assign fire      = load && !q_empty;
    assign beat_last = (idx_reg == q_beats - NW'(1));
    assign pop       = fire && beat_last;
    assign beat_byte = !q_desc.crlf ? q_desc.ch :
                       ((idx_reg == '0) ? CH_CR : CH_LF);

    always_comb
    begin
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = !q_empty;
        end
        if (fire)
        begin
            idx_next = beat_last ? '0 : idx_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg   <= beat_byte;
            bvalid_reg <= q_desc.bvalid;
            last_reg   <= beat_last;
            status_reg <= q_desc.st;
            col_reg    <= q_col;
            canon_reg  <= q_canon;
        end
    end

    assign col_ext   = {{OUT_COL_BITS{1'b0}}, col_reg};
    assign canon_ext = {{OUT_COL_BITS{1'b0}}, canon_reg};

    assign res_valid        = res_valid_reg;
    assign out_byte         = byte_reg;
    assign out_valid        = bvalid_reg;
    assign last             = last_reg;
    assign status           = status_reg;
    assign column_now       = col_ext[OUT_COL_BITS-1:0];
    assign canon_column_now = canon_ext[OUT_COL_BITS-1:0];

endmodule
`default_nettype wire

@@ rtl/core/tty_output_postprocessor.sv @@
`default_nettype none
// a taken byte is queued, then its first result beat is registered in the output stage
// throughput: one result beat per cycle while res_ready is high; a byte normally gives
// one beat, a cr-lf pair two, an expanded tab up to TAB_WIDTH; the output stage sets the pace
// input is taken every cycle while the two-entry queue has room
// reset: columns cleared, mode registers to their defaults, queue and output stage empty
// ----------------------------------------------------------------------------
// tty_output_postprocessor
// terminal output post-processor applying the termios output modes, with an
// apb-style register port for the mode bits
// ----------------------------------------------------------------------------
module tty_output_postprocessor #(
    parameter int TAB_WIDTH   = tty_pkg::TAB_WIDTH_DEF,
    parameter int COLUMN_BITS = tty_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tty_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [tty_pkg::DATA_BITS-1:0]        pwdata,
    output logic [tty_pkg::DATA_BITS-1:0]             prdata,
    output logic                                      pready,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           in_byte,
    input  wire logic [7:0]                           room,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output logic [7:0]                                out_byte,
    output logic                                      out_valid,
    output logic                                      last,
    output logic [1:0]                                status,
    output logic [tty_pkg::OUT_COL_BITS-1:0]          column_now,
    output logic [tty_pkg::OUT_COL_BITS-1:0]          canon_column_now
);
    import tty_pkg::*;

    localparam int NW = $clog2(TAB_WIDTH + 1);
    localparam int CW = COLUMN_BITS;
    localparam int DW = $bits(desc_t) + NW + 2 * CW;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    logic     rd_bit;

    desc_t          f_desc;
    logic [NW-1:0]  f_beats;
    logic [CW-1:0]  f_col;
    logic [CW-1:0]  f_canon;
    logic           take;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic [DW-1:0]  q_head;
    desc_t          q_desc;
    logic [NW-1:0]  q_beats;
    logic [CW-1:0]  q_col;
    logic [CW-1:0]  q_canon;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        rd_bit   = 1'b0;
        case (reg_idx)
            REG_POST_ENABLE:   rd_bit = cfg_reg.post_enable;
            REG_NL_TO_CRNL:    rd_bit = cfg_reg.nl_to_crnl;
            REG_CR_TO_NL:      rd_bit = cfg_reg.cr_to_nl;
            REG_NO_CR_AT_COL0: rd_bit = cfg_reg.no_cr_at_col0;
            REG_NL_RETURNS:    rd_bit = cfg_reg.nl_returns;
            REG_UPPER_CASE:    rd_bit = cfg_reg.upper_case;
            REG_EXPAND_TABS:   rd_bit = cfg_reg.expand_tabs;
            default:           rd_bit = 1'b0;
        endcase
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_POST_ENABLE:   cfg_next.post_enable   = pwdata[0];
                REG_NL_TO_CRNL:    cfg_next.nl_to_crnl    = pwdata[0];
                REG_CR_TO_NL:      cfg_next.cr_to_nl      = pwdata[0];
                REG_NO_CR_AT_COL0: cfg_next.no_cr_at_col0 = pwdata[0];
                REG_NL_RETURNS:    cfg_next.nl_returns    = pwdata[0];
                REG_UPPER_CASE:    cfg_next.upper_case    = pwdata[0];
                REG_EXPAND_TABS:   cfg_next.expand_tabs   = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    assign prdata = {{(DATA_BITS-1){1'b0}}, rd_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    tty_front #(
        .TAB_WIDTH   (TAB_WIDTH),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_byte     (in_byte),
        .room        (room),
        .take        (take),
        .desc        (f_desc),
        .beats       (f_beats),
        .col_after   (f_col),
        .canon_after (f_canon)
    );

    tty_fifo #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data ({f_desc, f_beats, f_col, f_canon}),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    assign {q_desc, q_beats, q_col, q_canon} = q_head;

    // back end
    tty_back #(
        .TAB_WIDTH   (TAB_WIDTH),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_desc           (q_desc),
        .q_beats          (q_beats),
        .q_col            (q_col),
        .q_canon          (q_canon),
        .pop              (q_pop),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .out_byte         (out_byte),
        .out_valid        (out_valid),
        .last             (last),
        .status           (status),
        .column_now       (column_now),
        .canon_column_now (canon_column_now)
    );

endmodule
`default_nettype wire

@@ rtl/core/tty_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tty_checker
// port-level checks on the result channel of the output post-processor
// ----------------------------------------------------------------------------
module tty_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 res_valid,
    input  wire logic                                 res_ready,
    input  wire logic [7:0]                           out_byte,
    input  wire logic                                 out_valid,
    input  wire logic                                 last,
    input  wire logic [1:0]                           status,
    input  wire logic [tty_pkg::OUT_COL_BITS-1:0]     column_now,
    input  wire logic [tty_pkg::OUT_COL_BITS-1:0]     canon_column_now
);
    import tty_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(last))
        else $error("result beat changed while stalled");

    // status beats carry no byte and close their item
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_EMIT |-> !out_valid && last && out_byte == 8'd0)
        else $error("status beat malformed");

    // emitted beats carry a byte
    a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_EMIT |-> out_valid)
        else $error("emitted beat without byte");

    // a run of beats follows without gaps and with the same columns
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last |=> res_valid && $stable(column_now)
            && $stable(canon_column_now))
        else $error("beat run broken");

endmodule

bind tty_output_postprocessor tty_checker u_tty_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the terminal output post-processor beat by beat against a shadow of
// its column state and output modes; directed corner cases, random traffic
// under several mode settings and a long receiver hold-off
// ----------------------------------------------------------------------------
module tb;
    import tty_pkg::*;

    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 40;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned COL_MAX       = (1 << COLUMN_BITS_DEF) - 1;

    typedef struct {
        logic [7:0]              ch;
        logic                    bvalid;
        logic                    lst;
        status_t                 st;
        logic [OUT_COL_BITS-1:0] col;
        logic [OUT_COL_BITS-1:0] canon;
    } beat_t;

    class opost_shadow;
        cfg_t        mode;
        int unsigned column;
        int unsigned canon;
        beat_t       due[$];
        int          mismatches;

        function new();
            mode       = CFG_RESET;
            column     = 0;
            canon      = 0;
            mismatches = 0;
        endfunction

        // cfg_t fields run in register order from the top bit down
        function void set_mode(reg_idx_t idx, logic v);
            mode[REG_EXPAND_TABS - idx] = v;
        endfunction

        function int unsigned col_add(int unsigned n);
            return (column + n > COL_MAX) ? COL_MAX : column + n;
        endfunction

        function void add_beat(logic [7:0] ch, logic bv, logic lst, status_t st);
            beat_t b;
            b.ch     = ch;
            b.bvalid = bv;
            b.lst    = lst;
            b.st     = st;
            b.col    = column[OUT_COL_BITS-1:0];
            b.canon  = canon[OUT_COL_BITS-1:0];
            due.push_back(b);
        endfunction

        function void post_char(logic [7:0] ch, logic [7:0] space);
            int unsigned n;
            logic [7:0]  c;
            c = ch;
            if (space == 0) begin
                add_beat(8'h00, 1'b0, 1'b1, ST_ROOM);
                return;
            end
            if (!mode.post_enable) begin
                add_beat(ch, 1'b1, 1'b1, ST_EMIT);
                return;
            end
            case (ch)
                CH_LF: begin
                    if (mode.nl_returns)
                        column = 0;
                    if (mode.nl_to_crnl) begin
                        if (space < 2) begin
                            add_beat(8'h00, 1'b0, 1'b1, ST_ROOM);
                        end
                        else begin
                            column = 0;
                            canon  = 0;
                            add_beat(CH_CR, 1'b1, 1'b0, ST_EMIT);
                            add_beat(CH_LF, 1'b1, 1'b1, ST_EMIT);
                        end
                    end
                    else begin
                        canon = column;
                        add_beat(CH_LF, 1'b1, 1'b1, ST_EMIT);
                    end
                end
                CH_CR: begin
                    if (mode.no_cr_at_col0 && column == 0) begin
                        add_beat(8'h00, 1'b0, 1'b1, ST_SUPP);
                    end
                    else if (mode.cr_to_nl) begin
                        if (mode.nl_returns) begin
                            column = 0;
                            canon  = 0;
                        end
                        add_beat(CH_LF, 1'b1, 1'b1, ST_EMIT);
                    end
                    else begin
                        column = 0;
                        canon  = 0;
                        add_beat(CH_CR, 1'b1, 1'b1, ST_EMIT);
                    end
                end
                CH_TAB: begin
                    n = TAB_WIDTH_DEF - (column % TAB_WIDTH_DEF);
                    if (!mode.expand_tabs) begin
                        column = col_add(n);
                        add_beat(CH_TAB, 1'b1, 1'b1, ST_EMIT);
                    end
                    else if (space < n) begin
                        add_beat(8'h00, 1'b0, 1'b1, ST_ROOM);
                    end
                    else begin
                        column = col_add(n);
                        for (int k = 0; k < n; k++)
                            add_beat(CH_SPACE, 1'b1, k == n - 1, ST_EMIT);
                    end
                end
                CH_BS: begin
                    if (column > 0)
                        column--;
                    add_beat(CH_BS, 1'b1, 1'b1, ST_EMIT);
                end
                default: begin
                    if (ch > CH_CTL_HI && ch != CH_DEL) begin
                        if (mode.upper_case && ch >= CH_LOW_A && ch <= CH_LOW_Z)
                            c = ch - CASE_OFFSET;
                        column = col_add(1);
                    end
                    add_beat(c, 1'b1, 1'b1, ST_EMIT);
                end
            endcase
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        endfunction

        function void match_beat(logic [7:0] ob, logic ov, logic ol, logic [1:0] os,
                                 logic [OUT_COL_BITS-1:0] oc,
                                 logic [OUT_COL_BITS-1:0] ocan);
            beat_t e;
            if (due.size() == 0) begin
                $error("result beat with nothing due: out_byte %0h", ob);
                mismatches++;
                return;
            end
            e = due.pop_front();
            if (ob !== e.ch)
                report("out_byte", e.ch, ob);
            if (ov !== e.bvalid)
                report("out_valid", e.bvalid, ov);
            if (ol !== e.lst)
                report("last", e.lst, ol);
            if (os !== e.st)
                report("status", e.st, os);
            if (oc !== e.col)
                report("column_now", e.col, oc);
            if (ocan !== e.canon)
                report("canon_column_now", e.canon, ocan);
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [ADDR_BITS-1:0]         paddr     = '0;
    logic [DATA_BITS-1:0]         pwdata    = '0;
    logic [DATA_BITS-1:0]         prdata;
    logic                         pready;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [7:0]                   in_byte   = '0;
    logic [7:0]                   room      = '0;
    logic                         res_valid;
    logic                         res_ready = 1'b0;
    logic [7:0]                   out_byte;
    logic                         out_valid;
    logic                         last;
    logic [1:0]                   status;
    logic [OUT_COL_BITS-1:0]      column_now;
    logic [OUT_COL_BITS-1:0]      canon_column_now;

    opost_shadow                  shadow    = new();
    bit                           quiet     = 1'b0;
    bit                           hold_req  = 1'b0;
    int unsigned                  cycles    = 0;

    tty_output_postprocessor i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_byte          (in_byte),
        .room             (room),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .out_byte         (out_byte),
        .out_valid        (out_valid),
        .last             (last),
        .status           (status),
        .column_now       (column_now),
        .canon_column_now (canon_column_now)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL tty_output_postprocessor");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                shadow.post_char(in_byte, room);
            if (res_valid && res_ready)
                shadow.match_beat(out_byte, out_valid, last, status, column_now,
                                  canon_column_now);
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int stretch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result sink: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int stall;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                res_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 30)
            begin
                stall = stretch();
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic [7:0] ch, logic [7:0] space);
        int gap;
        gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : stretch();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= ch;
        room     <= space;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic random_beat();
        logic [7:0] ch;
        logic [7:0] space;
        int         sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            ch = $urandom_range(CH_SPACE, CH_DEL - 1);
        else if (sel < 45)
            ch = $urandom_range(CH_LOW_A, CH_LOW_Z);
        else if (sel < 55)
            ch = CH_LF;
        else if (sel < 62)
            ch = CH_CR;
        else if (sel < 72)
            ch = CH_TAB;
        else if (sel < 78)
            ch = CH_BS;
        else if (sel < 85)
            ch = $urandom_range(0, CH_CTL_HI);
        else
            ch = $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (sel < 8)
            space = 8'h00;
        else if (sel < 25)
            space = $urandom_range(1, TAB_WIDTH_DEF);
        else if (sel < 40)
            space = 8'hFF;
        else
            space = $urandom_range(0, 255);
        send_beat(ch, space);
    endtask

    task automatic reg_write(reg_idx_t idx, logic v);
        logic [DATA_BITS-1:0] d;
        d    = $urandom;
        d[0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_mode(idx, v);
        @(posedge clk);
    endtask

    task automatic write_modes(cfg_t m);
        for (int i = REG_POST_ENABLE; i <= REG_EXPAND_TABS; i++)
            reg_write(reg_idx_t'(i), m[REG_EXPAND_TABS - i]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        cfg_t m;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modes
        send_beat(CH_LOW_A, 8'hFF);
        send_beat(8'h00, 8'h01);
        send_beat(8'hFF, 8'hFF);
        send_beat(CH_DEL, 8'hFF);
        send_beat(8'h80, 8'h01);
        send_beat(CH_BS, 8'hFF);
        send_beat(CH_LF, 8'h01);
        send_beat(CH_LF, 8'h02);
        send_beat(CH_BS, 8'hFF);
        send_beat(CH_TAB, 8'hFF);
        send_beat(CH_CR, 8'hFF);
        send_beat(CH_LOW_Z, 8'h00);
        send_beat(CH_CR, 8'hFF);
        settle();

        write_modes('{post_enable: 1'b1, nl_to_crnl: 1'b0, cr_to_nl: 1'b1,
                      no_cr_at_col0: 1'b1, nl_returns: 1'b1, upper_case: 1'b1,
                      expand_tabs: 1'b1});
        send_beat(CH_CR, 8'hFF);
        send_beat(CH_LOW_A, 8'hFF);
        send_beat(CH_LOW_Z, 8'hFF);
        send_beat(CH_LOW_Z + 1, 8'hFF);
        send_beat(CH_LOW_A - 1, 8'hFF);
        send_beat(CH_TAB, 8'h03);
        send_beat(CH_TAB, 8'h04);
        send_beat(CH_TAB, 8'hFF);
        send_beat(CH_CR, 8'hFF);
        send_beat(CH_LOW_A, 8'hFF);
        send_beat(CH_LF, 8'hFF);
        settle();

        write_modes('0);
        send_beat(CH_LOW_A, 8'h00);
        send_beat(CH_LF, 8'h01);
        send_beat(CH_TAB, 8'hFF);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                m = '1;
            else if (p == 1)
                m = '0;
            else
            begin
                m = cfg_t'($urandom_range(0, (1 << $bits(cfg_t)) - 1));
                if ($urandom_range(0, 4) != 0)
                    m.post_enable = 1'b1;
            end
            write_modes(m);
            quiet = (p == 2);
            if (p == 4)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) random_beat();
            settle();
        end

        if (shadow.mismatches == 0)
            $display("PASS tty_output_postprocessor");
        else
            $display("FAIL tty_output_postprocessor");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tty_pkg.sv
rtl/core/tty_front.sv
rtl/core/tty_fifo.sv
rtl/core/tty_back.sv
rtl/core/tty_output_postprocessor.sv
rtl/core/tty_checker.sv
dv/tb.sv
